>>> design/bitmap_set_with_ordered_scan_defines.svh
// Assertion macros shared by the bitmap set design files
`ifndef BITMAP_SET_WITH_ORDERED_SCAN_DEFINES_SVH
`define BITMAP_SET_WITH_ORDERED_SCAN_DEFINES_SVH
`ifndef SYNTHESIS
`define BSOS_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant violated");
`define BSOS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication violated");
`else
`define BSOS_ASSERT_ALWAYS(lbl, expr)
`define BSOS_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

>>> design/bsos_pkg.sv
// Shared request codes, command/status structs and a helper for the bitmap set
`default_nettype none
package bsos_pkg;
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_FETCH  = 2'd1;
	localparam logic [1:0] REQ_CLEAR  = 2'd2;

	typedef struct packed {
		logic capture;
		logic clr_init;
		logic clr_step;
		logic rd_ins;
		logic wr_ins;
		logic rd_pos;
		logic ev_pos;
		logic rd_sum;
		logic ev_sum;
		logic ev_word;
		logic set_none;
		logic out_load;
	} bsos_cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       val_ok;
		logic       pos_end;
		logic       pos_hit;
		logic       pos_lastw;
		logic       sum_hit;
		logic       sum_last;
		logic       clr_last;
		logic       out_free;
	} bsos_sts_t;

	// index of lowest set bit, zero for an empty word
	function automatic logic [5:0] lowest_set(input logic [63:0] w);
		logic [5:0] r;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			if (w[i]) r = 6'(i);
		end
		return r;
	endfunction
endpackage
`default_nettype wire

>>> design/bsos_req_if.sv
// Request channel: request code and value
`default_nettype none
interface bsos_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] in_value;
	modport source(output valid, req_type, in_value, input ready);
	modport sink(input valid, req_type, in_value, output ready);
endinterface
`default_nettype wire

>>> design/bsos_rsp_if.sv
// Response channel: found value and status
`default_nettype none
interface bsos_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] out_value;
	logic        status;
	modport source(output valid, out_value, status, input ready);
	modport sink(input valid, out_value, status, output ready);
endinterface
`default_nettype wire

>>> design/bsos_dp.sv
// Datapath: two-level bitmap memories, scan position, result register
`default_nettype none
`include "bitmap_set_with_ordered_scan_defines.svh"
module bsos_dp #(
	parameter int NUM_VALUES = 65536
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bsos_pkg::bsos_cmd_t  cmd,
	output bsos_pkg::bsos_sts_t  sts,
	input  logic [1:0]           req_type,
	input  logic [15:0]          in_value,
	bsos_rsp_if.source           rsp
);
	localparam int WORDS  = (NUM_VALUES + 63) / 64;
	localparam int SWORDS = (WORDS + 63) / 64;
	localparam int WAW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int SAW    = (SWORDS > 1) ? $clog2(SWORDS) : 1;
	localparam int VW     = WAW + 6;
	localparam int PW     = VW + 1;

	logic [63:0]     l0_mem [WORDS];
	logic [63:0]     sum_mem [SWORDS];
	logic [63:0]     l0_rd_q, sum_rd_q;
	logic [1:0]      req_q;
	logic [15:0]     val_q;
	logic [PW-1:0]   pos_q;
	logic [WAW-1:0]  clr_q, wsel_q;
	logic [SAW-1:0]  sidx_q;
	logic [5:0]      smask_q;
	logic [15:0]     rv_q, ov_val_q;
	logic            rs_q, ov_st_q, ov_q;

	logic [WAW+21:0]     vext;
	logic [WAW-1:0]      val_word, pos_word, sum_w;
	logic [5:0]          val_bit, pos_lo, val_sbit, tgt_sbit;
	logic [WAW+SAW+5:0]  val_wext;
	logic [SAW-1:0]      val_sidx, tgt_sidx, clr_saddr;
	logic [WAW:0]        tgt;
	logic [WAW+SAW+6:0]  tgt_ext;
	logic [63:0]         pos_m, sum_m;
	logic [VW-1:0]       pos_v, word_v;
	logic [VW+15:0]      pvx, wvx;
	logic [SAW+5:0]      sum_w_ext;
	logic [WAW+SAW-1:0]  clr_ext;
	logic                clr_sum_ok, pos_end, sum_hit;

	logic            l0_re, l0_we, s_re, s_we;
	logic [WAW-1:0]  l0_ra, l0_wa;
	logic [SAW-1:0]  s_ra, s_wa;
	logic [63:0]     l0_wd, s_wd;

	assign vext      = {{(WAW + 6){1'b0}}, val_q};
	assign val_word  = vext[WAW+5:6];
	assign val_bit   = vext[5:0];
	assign val_wext  = {{(SAW + 6){1'b0}}, val_word};
	assign val_sidx  = val_wext[SAW+5:6];
	assign val_sbit  = val_wext[5:0];
	assign pos_word  = pos_q[VW-1:6];
	assign pos_lo    = pos_q[5:0];
	assign pos_end   = pos_q >= PW'(NUM_VALUES);
	assign pos_m     = l0_rd_q & ({64{1'b1}} << pos_lo);
	assign pos_v     = {pos_word, bsos_pkg::lowest_set(pos_m)};
	assign pvx       = {16'b0, pos_v};
	assign tgt       = (WAW + 1)'(pos_word) + (WAW + 1)'(1);
	assign tgt_ext   = {{(SAW + 6){1'b0}}, tgt};
	assign tgt_sidx  = tgt_ext[SAW+5:6];
	assign tgt_sbit  = tgt_ext[5:0];
	assign sum_m     = sum_rd_q & ({64{1'b1}} << smask_q);
	assign sum_hit   = |sum_m;
	assign sum_w_ext = {sidx_q, bsos_pkg::lowest_set(sum_m)};
	assign sum_w     = sum_w_ext[WAW-1:0];
	assign word_v    = {wsel_q, bsos_pkg::lowest_set(l0_rd_q)};
	assign wvx       = {16'b0, word_v};
	assign clr_ext   = {{SAW{1'b0}}, clr_q};
	assign clr_sum_ok = clr_ext < (WAW + SAW)'(SWORDS);
	assign clr_saddr = clr_ext[SAW-1:0];

	always_comb begin
		sts.req       = req_q;
		sts.val_ok    = 32'(val_q) < 32'(NUM_VALUES);
		sts.pos_end   = pos_end;
		sts.pos_hit   = |pos_m;
		sts.pos_lastw = pos_word == WAW'(WORDS - 1);
		sts.sum_hit   = sum_hit;
		sts.sum_last  = sidx_q == SAW'(SWORDS - 1);
		sts.clr_last  = clr_q == WAW'(WORDS - 1);
		sts.out_free  = !ov_q || rsp.ready;
	end

	// memory port muxing
	always_comb begin
		l0_re = cmd.rd_ins || cmd.rd_pos || (cmd.ev_sum && sum_hit);
		l0_ra = cmd.rd_ins ? val_word : (cmd.rd_pos ? pos_word : sum_w);
		l0_we = cmd.clr_step || cmd.wr_ins;
		l0_wa = cmd.clr_step ? clr_q : val_word;
		l0_wd = cmd.clr_step ? 64'b0 : (l0_rd_q | (64'b1 << val_bit));
		s_re  = cmd.rd_ins || cmd.rd_sum;
		s_ra  = cmd.rd_ins ? val_sidx : sidx_q;
		s_we  = (cmd.clr_step && clr_sum_ok) || cmd.wr_ins;
		s_wa  = cmd.clr_step ? clr_saddr : val_sidx;
		s_wd  = cmd.clr_step ? 64'b0 : (sum_rd_q | (64'b1 << val_sbit));
	end

	always_ff @(posedge clk) begin
		if (l0_we) l0_mem[l0_wa] <= l0_wd;
		if (l0_re) l0_rd_q <= l0_mem[l0_ra];
	end

	always_ff @(posedge clk) begin
		if (s_we) sum_mem[s_wa] <= s_wd;
		if (s_re) sum_rd_q <= sum_mem[s_ra];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req_type;
			val_q <= in_value;
		end
		if (cmd.ev_pos && !(|pos_m)) begin
			sidx_q  <= tgt_sidx;
			smask_q <= tgt_sbit;
		end
		if (cmd.ev_sum && sum_hit) wsel_q <= sum_w;
		if (cmd.ev_sum && !sum_hit) begin
			sidx_q  <= sidx_q + SAW'(1);
			smask_q <= '0;
		end
		if (cmd.out_load) begin
			ov_val_q <= rv_q;
			ov_st_q  <= rs_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			clr_q <= '0;
			rv_q  <= '0;
			rs_q  <= 1'b0;
			ov_q  <= 1'b0;
		end else begin
			if (cmd.capture) begin
				rv_q <= '0;
				rs_q <= 1'b0;
			end
			if (cmd.clr_init) clr_q <= '0;
			if (cmd.clr_step) begin
				clr_q <= clr_q + WAW'(1);
				pos_q <= '0;
			end
			if (cmd.set_none) begin
				rs_q  <= 1'b1;
				pos_q <= PW'(NUM_VALUES);
			end
			if (cmd.ev_pos) begin
				if (|pos_m) begin
					rv_q  <= pvx[15:0];
					pos_q <= PW'(pos_v) + PW'(1);
				end else if (sts.pos_lastw) begin
					rs_q  <= 1'b1;
					pos_q <= PW'(NUM_VALUES);
				end
			end
			if (cmd.ev_sum && !sum_hit && sts.sum_last) begin
				rs_q  <= 1'b1;
				pos_q <= PW'(NUM_VALUES);
			end
			if (cmd.ev_word) begin
				rv_q  <= wvx[15:0];
				pos_q <= PW'(word_v) + PW'(1);
			end
			if (cmd.out_load) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
		end
	end

	assign rsp.valid     = ov_q;
	assign rsp.out_value = ov_val_q;
	assign rsp.status    = ov_st_q;

	`BSOS_ASSERT_ALWAYS(a_pos_in_range, pos_q <= PW'(NUM_VALUES))
	`BSOS_ASSERT_IMPL(a_rmw_order, cmd.wr_ins, $past(cmd.rd_ins))
endmodule
`default_nettype wire

>>> design/bsos_ctrl.sv
// Controller: sequences insert, fetch and clear over the datapath
`default_nettype none
`include "bitmap_set_with_ordered_scan_defines.svh"
module bsos_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  bsos_pkg::bsos_sts_t  sts,
	output bsos_pkg::bsos_cmd_t  cmd
);
	localparam logic [3:0] ST_CLR_RST = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_DISP    = 4'd2;
	localparam logic [3:0] ST_INS_WR  = 4'd3;
	localparam logic [3:0] ST_POS_EV  = 4'd4;
	localparam logic [3:0] ST_SUM_RD  = 4'd5;
	localparam logic [3:0] ST_SUM_EV  = 4'd6;
	localparam logic [3:0] ST_WORD_EV = 4'd7;
	localparam logic [3:0] ST_CLR_REQ = 4'd8;
	localparam logic [3:0] ST_DONE    = 4'd9;

	logic [3:0] state_q, state_d;

	assign req_ready = state_q == ST_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_CLR_RST: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DISP;
				end
			end
			ST_DISP: begin
				case (sts.req)
					bsos_pkg::REQ_INSERT: begin
						if (sts.val_ok) begin
							cmd.rd_ins = 1'b1;
							state_d    = ST_INS_WR;
						end else begin
							state_d = ST_DONE;
						end
					end
					bsos_pkg::REQ_FETCH: begin
						if (sts.pos_end) begin
							cmd.set_none = 1'b1;
							state_d      = ST_DONE;
						end else begin
							cmd.rd_pos = 1'b1;
							state_d    = ST_POS_EV;
						end
					end
					bsos_pkg::REQ_CLEAR: begin
						cmd.clr_init = 1'b1;
						state_d      = ST_CLR_REQ;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_INS_WR: begin
				cmd.wr_ins = 1'b1;
				state_d    = ST_DONE;
			end
			ST_POS_EV: begin
				cmd.ev_pos = 1'b1;
				if (sts.pos_hit || sts.pos_lastw) state_d = ST_DONE;
				else state_d = ST_SUM_RD;
			end
			ST_SUM_RD: begin
				cmd.rd_sum = 1'b1;
				state_d    = ST_SUM_EV;
			end
			ST_SUM_EV: begin
				cmd.ev_sum = 1'b1;
				if (sts.sum_hit) state_d = ST_WORD_EV;
				else if (sts.sum_last) state_d = ST_DONE;
				else state_d = ST_SUM_RD;
			end
			ST_WORD_EV: begin
				cmd.ev_word = 1'b1;
				state_d     = ST_DONE;
			end
			ST_CLR_REQ: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLR_RST;
		else state_q <= state_d;
	end

	`BSOS_ASSERT_ALWAYS(a_cmd_exclusive, $onehot0(cmd))
	`BSOS_ASSERT_IMPL(a_load_free, cmd.out_load, sts.out_free)
endmodule
`default_nettype wire

>>> design/bitmap_set_with_ordered_scan.sv
// Top level of the presence bitmap set with ordered scan
// Keeps one presence bit per value below NUM_VALUES in a 64-bit-word memory
// plus a summary memory with one bit per nonempty word. Insert marks a value
// (values at or above NUM_VALUES are dropped); fetch returns the next present
// value at or after the scan position and moves the position past it, or
// status 1 once nothing is left; clear empties the set and rewinds the scan.
// One request is in work at a time, with a result register on the output so
// a new request is taken while the last result waits. Insert reads the word
// and summary word of the value and writes both back; fetch reads the word at
// the scan position, then, if that does not settle it, summary words in turn
// (at most ((NUM_VALUES+63)/64+63)/64 of them, 16 by default) and last the
// word that a summary hit names; clear steps through every bitmap word.
// The scan latency is set by the single read port of each memory. After reset
// a clearing pass over every bitmap word runs before the first request is
// accepted.
`default_nettype none
module bitmap_set_with_ordered_scan #(
	parameter int NUM_VALUES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	bsos_req_if.sink    req,
	bsos_rsp_if.source  rsp
);
	bsos_pkg::bsos_cmd_t cmd;
	bsos_pkg::bsos_sts_t sts;

	// sequencer
	bsos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// bitmap storage, scan position and result register
	bsos_dp #(
		.NUM_VALUES (NUM_VALUES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req_type (req.req_type),
		.in_value (req.in_value),
		.rsp      (rsp)
	);
endmodule
`default_nettype wire
